FILE: rtl/lbqs_pkg.sv
// shared types and constants for the log bucket quantile sketch
package lbqs_pkg;

    localparam int BIN_COUNT = 256;
    localparam int BIN_AW    = $clog2(BIN_COUNT);
    localparam int USED_W    = $clog2(BIN_COUNT + 1);

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [2:0] ST_DONE  = 3'd0;
    localparam logic [2:0] ST_FOUND = 3'd1;
    localparam logic [2:0] ST_ZERO  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_MIN   = 3'd4;
    localparam logic [2:0] ST_MAX   = 3'd5;

    localparam logic [1:0] ADDR_ZERO_KEY = 2'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLR,
        S_FOLD_SUM,
        S_FOLD_MOVE,
        S_SHIFT_DN,
        S_BIN_RD,
        S_BIN_WR,
        S_Q_MUL_HI,
        S_Q_MUL_LO,
        S_Q_TARGET,
        S_Q_SCAN,
        S_Q_CHECK,
        S_OUT
    } t_state;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

FILE: rtl/lbqs_bin_ram.sv
// bin counter memory, one write port and one registered read port
module lbqs_bin_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [lbqs_pkg::BIN_AW-1:0] i_waddr,
    input  logic [15:0]                i_wdata,
    input  logic [lbqs_pkg::BIN_AW-1:0] i_raddr,
    output logic [15:0]                o_rdata
);
    import lbqs_pkg::*;

    logic [15:0] r_mem [BIN_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/lbqs_mul.sv
// shared registered 17x48 multiplier for the rank target
module lbqs_mul (
    input  logic        i_clk,
    input  logic [16:0] i_a,
    input  logic [47:0] i_b,
    output logic [64:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= 65'({48'd0, i_a} * {17'd0, i_b});
    end
endmodule

FILE: rtl/log_bucket_quantile_sketch_unit.sv
// top level: sequencer, window state and stream/apb ports of the quantile sketch
// request paths: add updates the zero counter or a bin, and may first widen the window
//   downward or fold it; query returns an early status or scans the bins; clear writes one bin per cycle
// throughput: one request at a time; ready is low from accept until the result beat is taken
// reset: synchronous active low; clears control and counters, then walks the clear state over every bin
module log_bucket_quantile_sketch_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] req_type, [33:2] bucket_key, [49:34] add_weight, [66:50] rank_fraction
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [34:3] found_key
    output logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lbqs_pkg::*;

    localparam logic [32:0] BINS33 = 33'(BIN_COUNT);

    t_state r_state, n_state;

    logic signed [31:0] r_zero_key;
    logic [1:0]  r_req,  n_req;
    logic signed [31:0] r_key, n_key;
    logic [15:0] r_w,    n_w;
    logic [16:0] r_rf,   n_rf;
    logic signed [31:0] r_lo, n_lo, r_hi, n_hi;
    logic [USED_W-1:0] r_used, n_used;
    logic r_has_bins, n_has_bins, r_coll, n_coll;
    logic [63:0] r_total, n_total, r_zw, n_zw;
    logic [USED_W:0] r_idx, n_idx;
    logic [32:0] r_c, n_c;          // shift distance
    logic [15:0] r_acc, n_acc;
    logic [63:0] r_cum, n_cum, r_tgt, n_tgt;
    logic [2:0]  r_st, n_st;
    logic signed [31:0] r_fkey, n_fkey;
    logic r_ovalid, n_ovalid;
    logic r_rd_ph, n_rd_ph;
    logic r_loaded, n_loaded;
    logic [BIN_AW-1:0] r_pos, n_pos;

    logic we;
    logic [BIN_AW-1:0] waddr, raddr;
    logic [15:0] wdata, rdata;
    logic [64:0] mul_p;
    logic [47:0] mul_b;

    lbqs_bin_ram u_ram (.i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
                        .i_raddr(raddr), .o_rdata(rdata));
    lbqs_mul u_mul (.i_clk(i_clk), .i_a(r_rf), .i_b(mul_b), .o_p(mul_p));

    assign pready = 1'b1;
    assign prdata = r_zero_key;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_fkey, r_st};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_key <= 32'sh8000_0000;
        end else if (psel && penable && pwrite && paddr == ADDR_ZERO_KEY) begin
            r_zero_key <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_idx <= '0; r_ovalid <= 1'b0; r_req <= REQ_CLEAR;
            r_has_bins <= 1'b0; r_coll <= 1'b0; r_total <= '0; r_zw <= '0;
            r_lo <= '0; r_hi <= '0; r_used <= '0; r_rd_ph <= 1'b0; r_loaded <= 1'b0;
        end else begin
            r_state <= n_state; r_idx <= n_idx; r_ovalid <= n_ovalid; r_req <= n_req;
            r_has_bins <= n_has_bins; r_coll <= n_coll; r_total <= n_total; r_zw <= n_zw;
            r_lo <= n_lo; r_hi <= n_hi; r_used <= n_used; r_rd_ph <= n_rd_ph;
            r_loaded <= n_loaded;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key; r_w <= n_w; r_rf <= n_rf; r_c <= n_c; r_acc <= n_acc;
        r_cum <= n_cum; r_tgt <= n_tgt; r_st <= n_st; r_fkey <= n_fkey; r_pos <= n_pos;
    end

    // wide key arithmetic on 33 bits
    logic signed [32:0] k33, lo33, hi33, d_lo, d_hi;
    assign k33  = {r_key[31], r_key};
    assign lo33 = {r_lo[31], r_lo};
    assign hi33 = {r_hi[31], r_hi};
    assign d_lo = k33 - lo33;
    assign d_hi = hi33 - k33;

    logic [USED_W:0] src;
    logic [63:0] cum_add;
    always_comb begin
        src = r_idx + r_c[USED_W:0];
        cum_add = r_cum + {48'd0, rdata};
        if (cum_add < r_cum) cum_add = '1;
        mul_b = (r_state == S_Q_MUL_HI) ? r_total[63:16] : {32'd0, r_total[15:0]};
    end

    always_comb begin
        n_state = r_state; n_req = r_req; n_key = r_key; n_w = r_w; n_rf = r_rf;
        n_lo = r_lo; n_hi = r_hi; n_used = r_used; n_has_bins = r_has_bins;
        n_coll = r_coll; n_total = r_total; n_zw = r_zw; n_idx = r_idx; n_c = r_c;
        n_acc = r_acc; n_cum = r_cum; n_tgt = r_tgt; n_st = r_st; n_fkey = r_fkey;
        n_ovalid = r_ovalid; n_rd_ph = r_rd_ph; n_loaded = r_loaded; n_pos = r_pos;
        we = 1'b0; waddr = r_idx[BIN_AW-1:0]; wdata = '0; raddr = r_idx[BIN_AW-1:0];
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_req = s_axis_tdata[1:0];
                    n_key = s_axis_tdata[33:2];
                    n_w   = (s_axis_tdata[49:34] == 16'd0) ? 16'd1 : s_axis_tdata[49:34];
                    n_rf  = s_axis_tdata[66:50];
                    n_st = ST_DONE; n_fkey = '0;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_OUT;
                if (r_req == REQ_CLEAR) begin
                    n_idx = '0; n_state = S_CLR;
                end else if (r_req == REQ_ADD) begin
                    n_total = r_total + {48'd0, r_w};
                    if (r_key == r_zero_key) begin
                        n_zw = r_zw + {48'd0, r_w};
                    end else if (!r_has_bins) begin
                        n_lo = r_key; n_hi = r_key; n_used = USED_W'(1);
                        n_has_bins = 1'b1;
                        we = 1'b1; waddr = '0; wdata = r_w;
                    end else if (r_key >= r_lo && r_key <= r_hi) begin
                        n_pos = d_lo[BIN_AW-1:0]; n_state = S_BIN_RD;
                    end else if (r_key > r_hi) begin
                        if (d_lo >= $signed(BINS33)) begin
                            // new low = key - BIN_COUNT + 1; c = new_low - low
                            n_c = 33'(d_lo - $signed(BINS33) + 33'sd1);
                            n_idx = '0; n_acc = '0; n_rd_ph = 1'b0;
                            n_state = S_FOLD_SUM;
                        end else begin
                            n_hi = r_key;
                            n_used = USED_W'(d_lo + 33'sd1);
                            n_pos = d_lo[BIN_AW-1:0]; n_state = S_BIN_RD;
                        end
                    end else if (r_coll) begin
                        n_pos = '0; n_state = S_BIN_RD;
                    end else if (d_hi >= $signed(BINS33)) begin
                        n_coll = 1'b1; n_pos = '0; n_state = S_BIN_RD;
                    end else begin
                        // widen downward: move bins up by s = low - key
                        n_c = 33'(lo33 - k33);
                        n_idx = (USED_W+1)'(BIN_COUNT - 1); n_rd_ph = 1'b0;
                        n_state = S_SHIFT_DN;
                    end
                end else if (r_req == REQ_QUERY) begin
                    if (r_total == 64'd0) n_st = ST_EMPTY;
                    else if (r_rf == 17'd0) n_st = ST_MIN;
                    else if (r_rf[16]) n_st = ST_MAX;
                    else n_state = S_Q_MUL_HI;
                end
            end
            S_CLR: begin
                we = 1'b1; wdata = '0;
                n_idx = r_idx + 1'b1;
                if (r_idx == (USED_W+1)'(BIN_COUNT - 1)) begin
                    n_lo = '0; n_hi = '0; n_used = '0; n_has_bins = 1'b0;
                    n_coll = 1'b0; n_total = '0; n_zw = '0; n_idx = '0;
                    n_state = r_loaded ? S_OUT : S_IDLE;
                    n_loaded = 1'b1;
                end
            end
            S_FOLD_SUM: begin
                // sum bins 0..c that lie in use, each bin read in an address phase and a data phase
                if (!r_rd_ph) begin
                    if (r_idx >= {1'b0, r_used} || {{(33-USED_W-1){1'b0}}, r_idx} > r_c) begin
                        n_idx = '0; n_state = S_FOLD_MOVE;
                    end else n_rd_ph = 1'b1;
                end else begin
                    n_acc = sat_add16(r_acc, rdata);
                    n_idx = r_idx + 1'b1; n_rd_ph = 1'b0;
                end
            end
            S_FOLD_MOVE: begin
                // bin[i] = bin[i+c] when in use, else zero; slot 0 gets acc
                if (!r_rd_ph) begin
                    if (r_idx == (USED_W+1)'(BIN_COUNT)) begin
                        n_lo = 32'(k33 - $signed(BINS33) + 33'sd1);
                        n_hi = r_key; n_used = USED_W'(BIN_COUNT); n_coll = 1'b1;
                        n_pos = BIN_AW'(BIN_COUNT - 1);
                        n_state = S_BIN_RD;
                    end else if (r_idx == '0) begin
                        we = 1'b1; wdata = r_acc; n_idx = r_idx + 1'b1;
                    end else if (r_c >= BINS33 ||
                                 {{(32-USED_W){1'b0}}, src} >= {{(32-USED_W){1'b0}}, 1'b0, r_used}) begin
                        we = 1'b1; wdata = '0; n_idx = r_idx + 1'b1;
                    end else begin
                        raddr = src[BIN_AW-1:0]; n_rd_ph = 1'b1;
                    end
                end else begin
                    we = 1'b1; wdata = rdata; n_idx = r_idx + 1'b1; n_rd_ph = 1'b0;
                end
            end
            S_SHIFT_DN: begin
                // top down: bin[j] = j >= s ? bin[j-s] : 0, then slot 0 = w
                if (!r_rd_ph) begin
                    if ({{(32-USED_W){1'b0}}, r_idx} < r_c) begin
                        we = 1'b1;
                        wdata = (r_idx == '0) ? r_w : 16'd0;
                        if (r_idx == '0) begin
                            n_lo = r_key; n_used = USED_W'(d_hi + 33'sd1);
                            n_state = S_OUT;
                        end else n_idx = r_idx - 1'b1;
                    end else begin
                        raddr = BIN_AW'(r_idx - r_c[USED_W:0]); n_rd_ph = 1'b1;
                    end
                end else begin
                    we = 1'b1;
                    wdata = (r_idx == '0) ? r_w : rdata;
                    n_rd_ph = 1'b0;
                    if (r_idx == '0) begin
                        n_lo = r_key; n_used = USED_W'(d_hi + 33'sd1);
                        n_state = S_OUT;
                    end else n_idx = r_idx - 1'b1;
                end
            end
            S_BIN_RD: begin
                raddr = r_pos; n_state = S_BIN_WR;
            end
            S_BIN_WR: begin
                we = 1'b1; waddr = r_pos; wdata = sat_add16(rdata, r_w);
                n_state = S_OUT;
            end
            S_Q_MUL_HI: begin
                n_state = S_Q_MUL_LO;
            end
            S_Q_MUL_LO: begin
                n_tgt = mul_p[63:0];
                n_state = S_Q_TARGET;
            end
            S_Q_TARGET: begin
                n_tgt = r_tgt + {16'd0, 48'((mul_p + 65'hFFFF) >> 16)};
                n_cum = r_zw;
                n_idx = '0;
                n_state = S_Q_SCAN;
            end
            S_Q_SCAN: begin
                if (r_zw != 64'd0 && r_zw >= r_tgt) begin
                    n_st = ST_ZERO; n_state = S_OUT;
                end else if (!r_has_bins) begin
                    n_st = ST_ZERO; n_state = S_OUT;
                end else if (r_idx >= {1'b0, r_used}) begin
                    n_st = ST_MAX; n_state = S_OUT;
                end else begin
                    n_state = S_Q_CHECK;
                end
            end
            S_Q_CHECK: begin
                if (rdata != 16'd0 && cum_add >= r_tgt) begin
                    n_st = ST_FOUND;
                    n_fkey = r_lo + 32'(r_idx);
                    n_state = S_OUT;
                end else begin
                    if (rdata != 16'd0) n_cum = cum_add;
                    n_idx = r_idx + 1'b1;
                    if (r_idx + 1'b1 >= {1'b0, r_used}) begin
                        n_st = ST_MAX; n_state = S_OUT;
                    end else begin
                        raddr = BIN_AW'(r_idx + 1'b1);
                        n_state = S_Q_CHECK;
                    end
                    if (n_state == S_Q_CHECK) n_state = S_Q_SCAN;
                end
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

FILE: tb/log_bucket_quantile_sketch_unit_tb.sv
// self-checking testbench for the log bucket quantile sketch unit
module log_bucket_quantile_sketch_unit_tb;
    import lbqs_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int NBINS = BIN_COUNT;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = 2 * NBINS + 16;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_key;
    } t_sketch_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    log_bucket_quantile_sketch_unit dut (.*);

    // sketch mirror
    logic [15:0] mir_bins [NBINS];
    longint      mir_low;
    longint      mir_high;
    longint      mir_used;
    bit          mir_has_bins;
    bit          mir_collapsed;
    logic [63:0] mir_total;
    logic [63:0] mir_zero_cnt;
    longint      mir_zero_key;

    t_sketch_result pending_results[$];
    int fail_count = 0;
    int cycle_count = 0;
    int src_idle_pct;
    int snk_stall_pct;
    int hold_req_cnt;
    int hold_seen = 0;
    int hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] add_sat16(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic void sketch_clear();
        for (int i = 0; i < NBINS; i++) mir_bins[i] = '0;
        mir_low = 0;
        mir_high = 0;
        mir_used = 0;
        mir_has_bins = 0;
        mir_collapsed = 0;
        mir_total = '0;
        mir_zero_cnt = '0;
    endfunction

    // slide the window so its top is new_high, low bins summed into slot 0
    function automatic void sketch_slide_up(longint new_high);
        longint new_low;
        longint c;
        longint src;
        logic [15:0] acc;
        acc = '0;
        new_low = new_high - NBINS + 1;
        c = new_low - mir_low;
        for (int i = 0; i < mir_used && i < NBINS; i++)
            if (i <= c) acc = add_sat16(acc, mir_bins[i]);
        for (int i = 0; i < NBINS; i++) begin
            src = i + c;
            mir_bins[i] = (src < mir_used && src < NBINS) ? mir_bins[src] : 16'd0;
        end
        mir_bins[0] = acc;
        mir_low = new_low;
        mir_high = new_high;
        mir_used = NBINS;
        mir_collapsed = 1;
    endfunction

    function automatic void sketch_add_bin(longint key, logic [15:0] w);
        longint s;
        if (!mir_has_bins) begin
            mir_low = key;
            mir_high = key;
            mir_bins[0] = w;
            mir_used = 1;
            mir_has_bins = 1;
        end else if (key >= mir_low && key <= mir_high) begin
            mir_bins[key - mir_low] = add_sat16(mir_bins[key - mir_low], w);
        end else if (key > mir_high) begin
            if (key - mir_low + 1 > NBINS) sketch_slide_up(key);
            mir_high = key;
            mir_used = mir_high - mir_low + 1;
            mir_bins[key - mir_low] = add_sat16(mir_bins[key - mir_low], w);
        end else if (mir_collapsed) begin
            mir_bins[0] = add_sat16(mir_bins[0], w);
        end else if (mir_high - key + 1 > NBINS) begin
            mir_bins[0] = add_sat16(mir_bins[0], w);
            mir_collapsed = 1;
        end else begin
            // widen downward: shift bins up by s
            s = mir_low - key;
            for (int j = NBINS - 1; j >= 0; j--)
                mir_bins[j] = (j >= s) ? mir_bins[j - s] : 16'd0;
            mir_bins[0] = w;
            mir_low = key;
            mir_used = mir_high - key + 1;
        end
    endfunction

    function automatic t_sketch_result sketch_quantile(logic [16:0] rf);
        t_sketch_result r;
        logic [63:0] target;
        logic [63:0] cum;
        logic [63:0] nxt;
        r = '0;
        if (mir_total == 0) begin
            r.status = ST_EMPTY;
            return r;
        end
        if (rf == 0) begin
            r.status = ST_MIN;
            return r;
        end
        if (rf >= 17'd65536) begin
            r.status = ST_MAX;
            return r;
        end
        target = 64'(rf) * (mir_total >> 16)
               + ((64'(rf) * 64'(mir_total[15:0]) + 64'hFFFF) >> 16);
        cum = mir_zero_cnt;
        if ((mir_zero_cnt != 0 && cum >= target) || !mir_has_bins) begin
            r.status = ST_ZERO;
            return r;
        end
        for (int i = 0; i < mir_used && i < NBINS; i++) begin
            if (mir_bins[i] != 0) begin
                nxt = cum + 64'(mir_bins[i]);
                cum = (nxt < cum) ? '1 : nxt;
                if (cum >= target) begin
                    r.status = ST_FOUND;
                    r.found_key = 32'(mir_low + i);
                    return r;
                end
            end
        end
        r.status = ST_MAX;
        return r;
    endfunction

    function automatic t_sketch_result sketch_request(logic [1:0] req, logic [31:0] key,
                                                      logic [15:0] w, logic [16:0] rf);
        t_sketch_result r;
        logic [15:0] wt;
        r = '0;
        r.status = ST_DONE;
        case (req)
            REQ_ADD: begin
                wt = (w == 0) ? 16'd1 : w;
                mir_total = mir_total + 64'(wt);
                if (longint'($signed(key)) == mir_zero_key)
                    mir_zero_cnt = mir_zero_cnt + 64'(wt);
                else
                    sketch_add_bin(longint'($signed(key)), wt);
            end
            REQ_QUERY: r = sketch_quantile(rf);
            REQ_CLEAR: sketch_clear();
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        fail_count++;
    endtask

    task automatic send_request(logic [1:0] req, logic [31:0] key, logic [15:0] w,
                                logic [16:0] rf);
        t_sketch_result exp_res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, rf, w, key, req};
        do @(posedge i_clk); while (!s_axis_tready);
        exp_res = sketch_request(req, key, w, rf);
        pending_results = {pending_results, exp_res};
    endtask

    task automatic add_key(logic [31:0] key, logic [15:0] w);
        send_request(REQ_ADD, key, w, 17'($urandom));
    endtask

    task automatic query_at(logic [16:0] rf);
        send_request(REQ_QUERY, $urandom, 16'($urandom), rf);
    endtask

    // sender stops until every outstanding result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_zero_key(logic [31:0] v);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_ZERO_KEY;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        mir_zero_key = longint'($signed(v));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_directed();
        query_at(17'd32768);                   // empty sketch
        add_key(32'd5, 16'd0);                 // zero weight counts as one
        add_key(32'd5, 16'hFFFF);              // bin saturates
        add_key(32'h8000_0000, 16'd7);         // default zero key
        query_at(17'd0);
        query_at(17'd65536);
        query_at(17'd1);
        query_at(17'd65535);
        add_key(32'd6, 16'd3);
        add_key(32'h7FFF_FFFF, 16'hFFFF);      // far above: whole window folds
        add_key(32'h8000_0001, 16'd2);         // below after collapse
        query_at(17'd32768);
        query_at(17'h1FFFF);
        send_request(REQ_UNUSED, '1, '1, '1);  // ignored request type
        send_request(REQ_CLEAR, '0, '0, '0);
        add_key(32'd100, 16'd1);
        add_key(-32'sd155, 16'd4);             // widens down to the full window
        add_key(-32'sd156, 16'd9);             // just out of reach: slot 0
        add_key(32'd400, 16'd5);               // slide up
        query_at(17'd20000);
        query_at(17'd60000);
        send_request(REQ_CLEAR, '1, '1, '1);
        add_key(32'h8000_0000, 16'd1);         // only zero counter in use
        query_at(17'd65535);
    endtask

    task automatic test_random(int n, logic [31:0] zkey);
        int centre;
        int r;
        logic [15:0] w;
        logic [31:0] key;
        write_zero_key(zkey);
        centre = $urandom_range(2000) - 1000;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            w = ($urandom_range(9) == 0) ? 16'($urandom) :
                ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 60));
            centre = centre + $urandom_range(8) - 4;
            if ($urandom_range(60) == 0) centre = $urandom;
            if (r < 60) begin
                key = 32'(centre + $urandom_range(400) - 200);
                if ($urandom_range(19) == 0) key = $urandom;
                if ($urandom_range(24) == 0) key = zkey;
                add_key(key, w);
            end else if (r < 94) begin
                case ($urandom_range(9))
                    0: query_at(17'd0);
                    1: query_at(17'd65536);
                    2: query_at(17'($urandom));
                    default: query_at(17'($urandom_range(1, 65535)));
                endcase
            end else if (r < 97) begin
                send_request(REQ_UNUSED, $urandom, 16'($urandom), 17'($urandom));
            end else begin
                send_request(REQ_CLEAR, $urandom, 16'($urandom), 17'($urandom));
            end
        end
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        hold_req_cnt++;
        for (int k = 0; k < 12; k++) begin
            add_key(32'(k * 37), 16'(k));
            query_at(17'($urandom_range(1, 65535)));
        end
    endtask

    // sink side: random stalls plus long hold-offs
    always @(posedge i_clk) begin
        if (hold_req_cnt != hold_seen) begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_req_cnt;
        end
        if (hold_left > 0) hold_left--;
        m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        t_sketch_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report("unexpected beat", m_axis_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[2:0] != want.status)
                    report("status", 32'(m_axis_tdata[2:0]), 32'(want.status));
                if (m_axis_tdata[34:3] != want.found_key)
                    report("found_key", m_axis_tdata[34:3], want.found_key);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        hold_req_cnt = 0;
        src_idle_pct = 14;
        snk_stall_pct = 85;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sketch_clear();
        mir_zero_key = -64'sd2147483648;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(280, 32'hFFFF_FFFF);
        test_backpressure();
        src_idle_pct = 85;
        snk_stall_pct = 14;
        test_random(280, 32'd0);
        src_idle_pct = 0;
        snk_stall_pct = 0;
        test_random(150, 32'h7FFF_FFFF);
        test_random(150, 32'h8000_0000);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/lbqs_pkg.sv
rtl/lbqs_bin_ram.sv
rtl/lbqs_mul.sv
rtl/log_bucket_quantile_sketch_unit.sv
tb/log_bucket_quantile_sketch_unit_tb.sv
